/* hw/rtl/h2r_pkg.sv */
// constants shared by the hsv to rgb converter
// fixed-point hue wrap, reciprocal and sector codes; no dependencies
package h2r_pkg;

	localparam int HUE_W   = 16;
	localparam int SAT_W   = 9;
	localparam int VAL_W   = 8;
	localparam int COL_W   = 8;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 24;

	// hue plus 32768 is the offset-binary form; 1792 more makes six whole turns
	localparam logic [16:0] HUE_BIAS    = 17'd1792;
	localparam logic [12:0] RECIP_15    = 13'd4369;
	localparam logic [9:0]  SECTOR_SPAN = 10'd960;
	localparam logic [5:0]  RECIP_6     = 6'd43;
	localparam logic [8:0]  SAT_FULL    = 9'd256;
	localparam logic [16:0] UNITY_16    = 17'd65536;

	localparam logic [2:0] SEC_RED     = 3'd0;
	localparam logic [2:0] SEC_YELLOW  = 3'd1;
	localparam logic [2:0] SEC_GREEN   = 3'd2;
	localparam logic [2:0] SEC_CYAN    = 3'd3;
	localparam logic [2:0] SEC_BLUE    = 3'd4;
	localparam logic [2:0] SEC_MAGENTA = 3'd5;

endpackage

/* hw/rtl/hsv_to_rgb_converter.sv */
// hsv to rgb converter: seven-stage pipeline, one stream in and one out
// depends on h2r_pkg for widths, constants and sector codes
//
// Takes one HSV item per clock and returns one RGB item per clock as long as the
// output is not stalled by m_tready; every stage has its own valid bit and a
// stage advances whenever the stage after it is empty or moving, so bubbles are
// squeezed out during a stall. Hue wrap and sector split use constant
// reciprocal multiplies over stages one to three, the fraction and p in stage
// four, the q and t weights in stage five, their products in stage six, and
// stage seven places the components by sector into the output register.
// s_tdata: hue[15:0] signed, saturation[24:16], brightness[32:25], zeros above.
// m_tdata: red[7:0], green[15:8], blue[23:16].
module hsv_to_rgb_converter
	import h2r_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // hue, saturation, brightness
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // red, green, blue
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	assign en_s7 = !vld_s7 || m_tready;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign s_tready = en_s1;
	assign m_tvalid = vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	// stage 1: bias hue to non-negative, clamp saturation
	logic [HUE_W-1:0] hue_in;
	logic [SAT_W-1:0] sat_in;
	logic [VAL_W-1:0] val_in;
	logic [16:0]      hx_s1;
	logic [SAT_W-1:0] sat_s1;
	logic [VAL_W-1:0] val_s1;

	assign hue_in = s_tdata[15:0];
	assign sat_in = s_tdata[24:16];
	assign val_in = s_tdata[32:25];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			hx_s1  <= {1'b0, ~hue_in[15], hue_in[14:0]} + HUE_BIAS;
			sat_s1 <= (sat_in > SAT_FULL) ? SAT_FULL : sat_in;
			val_s1 <= val_in;
		end
	end

	// stage 2: number of whole sectors, (x/64)/15
	logic [24:0]      div15_prod;
	logic [6:0]       nsec_s2;
	logic [16:0]      hx_s2;
	logic [SAT_W-1:0] sat_s2;
	logic [VAL_W-1:0] val_s2;

	assign div15_prod = 25'({1'b0, hx_s1[16:6]} + 12'd1) * 25'(RECIP_15);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			nsec_s2 <= div15_prod[22:16];
			hx_s2   <= hx_s1;
			sat_s2  <= sat_s1;
			val_s2  <= val_s1;
		end
	end

	// stage 3: remainder within the sector and sector index mod 6
	logic [16:0]      span_prod;
	logic [11:0]      div6_prod;
	logic [3:0]       turns;
	logic [6:0]       sec_full;
	logic [9:0]       rem_s3;
	logic [2:0]       sector_s3;
	logic [SAT_W-1:0] sat_s3;
	logic [VAL_W-1:0] val_s3;

	assign span_prod = 17'(nsec_s2) * 17'(SECTOR_SPAN);
	assign div6_prod = 12'(nsec_s2) * 12'(RECIP_6);
	assign turns     = div6_prod[11:8];
	assign sec_full  = nsec_s2 - 7'(turns) * 7'd6;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rem_s3    <= 10'(hx_s2 - span_prod);
			sector_s3 <= sec_full[2:0];
			sat_s3    <= sat_s2;
			val_s3    <= val_s2;
		end
	end

	// stage 4: fraction f = rem*4/15, and p
	logic [25:0]      frac_prod;
	logic [16:0]      p_prod;
	logic [7:0]       frac_s4;
	logic [COL_W-1:0] p_s4;
	logic [2:0]       sector_s4;
	logic [SAT_W-1:0] sat_s4;
	logic [VAL_W-1:0] val_s4;

	assign frac_prod = 26'({1'b0, rem_s3, 2'b00} + 13'd1) * 26'(RECIP_15);
	assign p_prod    = 17'(val_s3) * 17'(SAT_FULL - sat_s3);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			frac_s4   <= frac_prod[23:16];
			p_s4      <= p_prod[15:8];
			sector_s4 <= sector_s3;
			sat_s4    <= sat_s3;
			val_s4    <= val_s3;
		end
	end

	// stage 5: weights for q and t
	logic [16:0]      sf_prod;
	logic [16:0]      sfc_prod;
	logic [16:0]      kq_s5;
	logic [16:0]      kt_s5;
	logic [COL_W-1:0] p_s5;
	logic [2:0]       sector_s5;
	logic [VAL_W-1:0] val_s5;

	assign sf_prod  = 17'(sat_s4) * 17'(frac_s4);
	assign sfc_prod = 17'(sat_s4) * 17'(SAT_FULL - 9'(frac_s4));

	always_ff @(posedge clk) begin
		if (en_s5) begin
			kq_s5     <= UNITY_16 - sf_prod;
			kt_s5     <= UNITY_16 - sfc_prod;
			p_s5      <= p_s4;
			sector_s5 <= sector_s4;
			val_s5    <= val_s4;
		end
	end

	// stage 6: q and t; zero saturation makes p, q and t all equal v
	logic [24:0]      q_prod;
	logic [24:0]      t_prod;
	logic [COL_W-1:0] q_s6;
	logic [COL_W-1:0] t_s6;
	logic [COL_W-1:0] p_s6;
	logic [2:0]       sector_s6;
	logic [VAL_W-1:0] val_s6;

	assign q_prod = 25'(val_s5) * 25'(kq_s5);
	assign t_prod = 25'(val_s5) * 25'(kt_s5);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			q_s6      <= q_prod[23:16];
			t_s6      <= t_prod[23:16];
			p_s6      <= p_s5;
			sector_s6 <= sector_s5;
			val_s6    <= val_s5;
		end
	end

	// stage 7: place by sector
	logic [COL_W-1:0] red_c, green_c, blue_c;
	logic [OUT_W-1:0] rgb_s7;

	always_comb begin
		case (sector_s6)
			SEC_RED: begin
				red_c = val_s6; green_c = t_s6; blue_c = p_s6;
			end
			SEC_YELLOW: begin
				red_c = q_s6; green_c = val_s6; blue_c = p_s6;
			end
			SEC_GREEN: begin
				red_c = p_s6; green_c = val_s6; blue_c = t_s6;
			end
			SEC_CYAN: begin
				red_c = p_s6; green_c = q_s6; blue_c = val_s6;
			end
			SEC_BLUE: begin
				red_c = t_s6; green_c = p_s6; blue_c = val_s6;
			end
			default: begin
				red_c = val_s6; green_c = p_s6; blue_c = q_s6;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			rgb_s7 <= {blue_c, green_c, red_c};
		end
	end

	assign m_tdata = rgb_s7;

	// remainder stays inside one sector
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> rem_s3 < SECTOR_SPAN)
		else $error("sector remainder out of range");

	// sector index is one of six
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> sector_s4 <= SEC_MAGENTA)
		else $error("sector index out of range");

	// zero saturation leaves full weights for q and t
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && sat_s4 == '0 && en_s5) |=> (kq_s5 == UNITY_16 && kt_s5 == UNITY_16))
		else $error("gray item lost unity weight");

	// an accepted item lands in the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted item not captured");

endmodule

/* sim/hsv_stream_checker.sv */
// stream checker for the hsv to rgb converter: predicts each color and compares
// results in order; depends on h2r_pkg for widths, constants and sector codes
`timescale 1ns / 100ps

module hsv_stream_checker
	import h2r_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // hue, saturation, brightness
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,  // red, green, blue
	output int               fails,
	output int               outstanding,
	output int               colors_checked,
	output int               grays_seen,
	output int               clamps_seen,
	output logic [5:0]       sectors_seen
);

	localparam int HUE_TURN = 5760;

	typedef struct packed {
		logic [IN_W-34:0]   pad;
		logic [VAL_W-1:0]   brightness;
		logic [SAT_W-1:0]   saturation;
		logic [HUE_W-1:0]   hue;
	} hsv_t;

	typedef struct packed {
		logic [COL_W-1:0] blue;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] red;
	} rgb_t;

	rgb_t pending_rgb[$];

	// sector comes back as -1 for gray
	function automatic rgb_t convert_hsv(hsv_t c, output int sector);
		int h, s, v, hw, rem, f, p, q, t;
		rgb_t o;
		h = $signed(c.hue);
		s = (c.saturation > SAT_FULL) ? int'(SAT_FULL) : int'(c.saturation);
		v = c.brightness;
		sector = -1;
		if (s == 0) begin
			o.red   = COL_W'(v);
			o.green = COL_W'(v);
			o.blue  = COL_W'(v);
		end else begin
			// remainder follows the sign of the dividend, so fold negatives up a turn
			hw = h % HUE_TURN;
			if (hw < 0)
				hw += HUE_TURN;
			sector = hw / int'(SECTOR_SPAN);
			rem = hw % int'(SECTOR_SPAN);
			f = (rem * 256) / int'(SECTOR_SPAN);
			p = (v * (256 - s)) >> 8;
			q = (v * (int'(UNITY_16) - s * f)) >> 16;
			t = (v * (int'(UNITY_16) - s * (256 - f))) >> 16;
			case (3'(sector))
				SEC_RED: begin
					o.red = COL_W'(v); o.green = COL_W'(t); o.blue = COL_W'(p);
				end
				SEC_YELLOW: begin
					o.red = COL_W'(q); o.green = COL_W'(v); o.blue = COL_W'(p);
				end
				SEC_GREEN: begin
					o.red = COL_W'(p); o.green = COL_W'(v); o.blue = COL_W'(t);
				end
				SEC_CYAN: begin
					o.red = COL_W'(p); o.green = COL_W'(q); o.blue = COL_W'(v);
				end
				SEC_BLUE: begin
					o.red = COL_W'(t); o.green = COL_W'(p); o.blue = COL_W'(v);
				end
				default: begin
					o.red = COL_W'(v); o.green = COL_W'(p); o.blue = COL_W'(q);
				end
			endcase
		end
		return o;
	endfunction

	always @(posedge clk) begin
		rgb_t want, got;
		hsv_t item;
		int sector;
		if (!arst_n) begin
			fails = 0;
			colors_checked = 0;
			grays_seen = 0;
			clamps_seen = 0;
			sectors_seen = '0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_rgb.size() == 0) begin
					$error("unexpected item on output: %h", m_tdata);
					fails++;
				end else begin
					want = pending_rgb.pop_front();
					colors_checked++;
					if (got.red !== want.red) begin
						$error("red: expected %0d, got %0d", want.red, got.red);
						fails++;
					end
					if (got.green !== want.green) begin
						$error("green: expected %0d, got %0d", want.green, got.green);
						fails++;
					end
					if (got.blue !== want.blue) begin
						$error("blue: expected %0d, got %0d", want.blue, got.blue);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				item = s_tdata;
				pending_rgb.push_back(convert_hsv(item, sector));
				if (sector < 0)
					grays_seen++;
				else
					sectors_seen[sector] = 1'b1;
				if (item.saturation > SAT_FULL)
					clamps_seen++;
			end
			outstanding = pending_rgb.size();
		end
	end

endmodule

/* sim/tb_top.sv */
// top of the hsv to rgb converter testbench: clock, reset, stream stimulus and verdict
// depends on h2r_pkg, the converter and hsv_stream_checker
`timescale 1ns / 100ps

module tb_top;
	import h2r_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 200;
	localparam int DRAIN       = 20;
	localparam int BLOCKS      = 10;
	localparam int BLOCK_LEN   = 50;
	localparam int N_DIRECTED  = 25;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;  // hue, saturation, brightness
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;       // red, green, blue

	int         fails, outstanding, colors_checked, grays_seen, clamps_seen;
	logic [5:0] sectors_seen;
	int         cycles = 0;
	bit         calm = 1'b0;
	// number of long output holds asked for so far
	int         squeeze_req = 0;

	// sector edges, hue extremes, wrap, gray and saturation above full
	int dir_hue[N_DIRECTED] = '{0, 959, 960, 1919, 1920, 2879, 2880, 3839, 3840, 4799,
		4800, 5759, 5760, -1, -5760, -32768, 32767, 1000, -3000, 2000,
		3000, 4000, 500, 1500, -12345};
	int dir_sat[N_DIRECTED] = '{256, 256, 256, 256, 256, 256, 256, 200, 256, 256,
		128, 256, 256, 256, 256, 256, 256, 0, 0, 511,
		257, 1, 255, 256, 300};
	int dir_val[N_DIRECTED] = '{255, 255, 255, 255, 255, 255, 255, 255, 255, 255,
		255, 255, 255, 255, 200, 255, 255, 173, 255, 255,
		99, 255, 255, 0, 1};

	always #1 clk = ~clk;

	hsv_to_rgb_converter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hsv_stream_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.fails          (fails),
		.outstanding    (outstanding),
		.colors_checked (colors_checked),
		.grays_seen     (grays_seen),
		.clamps_seen    (clamps_seen),
		.sectors_seen   (sectors_seen)
	);

	function automatic logic [IN_W-1:0] pack_hsv(int h, int s, int v);
		return IN_W'({VAL_W'(v), SAT_W'(s), HUE_W'(h)});
	endfunction

	function automatic logic [IN_W-1:0] random_hsv();
		int s;
		case ($urandom_range(0, 9))
			0: s = 0;
			1: s = 256;
			2: s = $urandom_range(257, 511);
			default: s = $urandom_range(1, 255);
		endcase
		// half full-range hue, half within one turn
		if ($urandom_range(0, 1))
			return pack_hsv($urandom, s, $urandom_range(0, 255));
		return pack_hsv($urandom_range(0, 5759), s, $urandom_range(0, 255));
	endfunction

	task automatic send_color(input logic [IN_W-1:0] color);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= color;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d colors still due", cycles, outstanding);
			$display("== FAIL ==");
			$finish;
		end
	end

	// output side: random stalls, plus one long hold-off per squeeze request
	initial begin
		int stall;
		int holds_done;
		holds_done = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (squeeze_req > holds_done) begin
				holds_done++;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			stall = calm ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_color(pack_hsv(dir_hue[i], dir_sat[i], dir_val[i]));

		for (int b = 0; b < BLOCKS; b++) begin
			// some blocks run back to back; two of them also get a long output hold
			calm = (b % 4 == 1) || (b == 6);
			if (b == 1 || b == 6)
				squeeze_req++;
			for (int j = 0; j < BLOCK_LEN; j++)
				send_color(random_hsv());
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;
		// let the checker log the last accepted item before polling its count
		@(posedge clk);

		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("checked %0d colors: %0d gray, %0d with saturation above full",
			colors_checked, grays_seen, clamps_seen);
		$display("sectors reached %b, two long output holds, %0d cycles", sectors_seen, cycles);
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", fails);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
